/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define PFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that cond holds in the cycle after trig, outside reset.
`define PFE_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

/* design/pfe_pkg.sv */
`default_nettype none

package pfe_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int MAP_ENTRIES     = 256;
  localparam int COORD_BITS      = 16;

  localparam int PAL_AW    = $clog2(PALETTE_ENTRIES);
  localparam int MAP_AW    = $clog2(MAP_ENTRIES);
  localparam int VERT_BITS = 17;
  localparam int NUM_TYPES = 6;
  localparam int NUM_FACES = 6;

  // face queue between colour lookup and vertex emitter
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] BYTE_FULL = 8'hFF;

  typedef enum logic [1:0] {
    ACT_PAL_WR = 2'd0,
    ACT_MAP_WR = 2'd1,
    ACT_EXPAND = 2'd2
  } action_t;

  localparam logic CFG_KEY_COLOUR  = 1'b0;
  localparam logic CFG_DIRECT_MODE = 1'b1;

  // offset selectors
  localparam logic [2:0] SEL_ZERO  = 3'd0;
  localparam logic [2:0] SEL_EXT_X = 3'd1;
  localparam logic [2:0] SEL_EXT_Y = 3'd2;
  localparam logic [2:0] SEL_EXT_Z = 3'd3;
  localparam logic [2:0] SEL_ORD0  = 3'd4;
  localparam logic [2:0] SEL_ORD1  = 3'd5;
  localparam logic [2:0] SEL_ORD2  = 3'd6;
  localparam logic [2:0] SEL_ORD3  = 3'd7;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS:0]   sum_t;
  typedef logic [VERT_BITS-1:0]  vert_t;
  typedef logic [PAL_AW-1:0]     pal_addr_t;
  typedef logic [MAP_AW-1:0]     map_addr_t;
  typedef logic [FIFO_AW-1:0]    fifo_ptr_t;
  typedef logic [FIFO_AW:0]      fifo_cnt_t;
  typedef logic [FIFO_AW+1:0]    credit_t;

  typedef struct packed {
    coord_t     org_x;
    coord_t     org_y;
    coord_t     org_z;
    coord_t     ext_x;
    coord_t     ext_y;
    coord_t     ext_z;
    coord_t     ord0;
    coord_t     ord1;
    coord_t     ord2;
    coord_t     ord3;
    logic [2:0] ptype;
  } geom_t;

  typedef struct packed {
    geom_t       geom;
    logic [2:0]  face;
    logic [23:0] rgb;
    logic        last;
    logic        bad;
  } face_entry_t;

  // per type, per vertex: offset selector for x, y, z
  localparam logic [2:0] VERT_RULE [NUM_TYPES][8][3] = '{
    '{ '{0,0,3}, '{0,2,3}, '{0,2,0}, '{0,0,0}, '{1,4,7}, '{1,6,7}, '{1,6,5}, '{1,4,5} },
    '{ '{1,0,0}, '{1,2,0}, '{1,2,3}, '{1,0,3}, '{0,4,5}, '{0,6,5}, '{0,6,7}, '{0,4,7} },
    '{ '{0,0,0}, '{1,0,0}, '{1,0,3}, '{0,0,3}, '{4,2,5}, '{6,2,5}, '{6,2,7}, '{4,2,7} },
    '{ '{1,2,0}, '{0,2,0}, '{0,2,3}, '{1,2,3}, '{6,0,5}, '{4,0,5}, '{4,0,7}, '{6,0,7} },
    '{ '{0,2,0}, '{1,2,0}, '{1,0,0}, '{0,0,0}, '{4,7,3}, '{6,7,3}, '{6,5,3}, '{4,5,3} },
    '{ '{0,0,3}, '{1,0,3}, '{1,2,3}, '{0,2,3}, '{4,5,0}, '{6,5,0}, '{6,7,0}, '{4,7,0} }
  };

  // vertex used by each corner of each face
  localparam logic [2:0] FACE_CORNERS [NUM_FACES][4] = '{
    '{4,5,1,0}, '{5,6,2,1}, '{6,7,3,2}, '{7,4,0,3}, '{0,1,2,3}, '{7,6,5,4}
  };

  function automatic coord_t sel_value(geom_t g, logic [2:0] code);
    coord_t v;
    case (code)
      SEL_EXT_X: v = g.ext_x;
      SEL_EXT_Y: v = g.ext_y;
      SEL_EXT_Z: v = g.ext_z;
      SEL_ORD0:  v = g.ord0;
      SEL_ORD1:  v = g.ord1;
      SEL_ORD2:  v = g.ord2;
      SEL_ORD3:  v = g.ord3;
      default:   v = '0;
    endcase
    return v;
  endfunction

  function automatic vert_t vertex_coord(coord_t base, coord_t off);
    sum_t s;
    s = sum_t'(base) + sum_t'(off);
    return vert_t'(s);
  endfunction

  // map entry -> palette index; any byte other than 00/FF falls back to idx
  function automatic logic [7:0] map_to_index(logic [31:0] entry, logic [7:0] idx);
    logic [3:0] bits;
    logic       ok;
    logic [7:0] b;
    bits = '0;
    ok   = 1'b1;
    for (int i = 0; i < 4; i++) begin
      b = entry[8*i +: 8];
      if (b == BYTE_FULL) begin
        bits[i] = 1'b1;
      end else if (b != 8'h00) begin
        ok = 1'b0;
      end
    end
    return ok ? {4'h0, bits} : idx;
  endfunction

endpackage

`default_nettype wire

/* design/pyramid_face_expander_unit.sv */
// Pyramid face expander.
// Input channel (in_valid/in_ready): action 0 writes a palette entry, 1 writes a
// colour-map entry, 2 expands a pyramid, 3 is dropped. Writes produce no items.
// An expand produces 4 vertex items per drawn face (up to 24), faces in order
// 0..5, corners 0..3; a bad pyramid_type produces one item with bad_type set.
// 'last' marks the final item of an expand. An expand of a valid type with
// every face keyed out produces nothing.
// Output channel (out_valid/out_ready) is a registered stage; a stalled
// receiver holds it, and up to FIFO_DEPTH resolved faces back up behind it
// before the lookup pipe stops issuing.
// Throughput: one item per cycle on the output while the receiver is ready
// and the face queue is not empty. The next input is taken once all faces of
// the current expand have been issued to the lookup pipe (one face per cycle
// while queue credit is available), so consecutive expands overlap.
// Colour lookup: map RAM read, then palette RAM read, both synchronous.
// Table writes are held off while an expand still has faces to issue.
// Reset clears control state and config (key off, map mode); table contents
// are undefined until written.
// Config port: cfg_we/cfg_index/cfg_data, write while the unit is idle.

`default_nettype none
`include "assert_macros.svh"

module pyramid_face_expander_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // config
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [8:0]  cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  table_index,
  input  wire logic [31:0] table_data,
  input  wire logic [15:0] origin_x,
  input  wire logic [15:0] origin_y,
  input  wire logic [15:0] origin_z,
  input  wire logic [15:0] extent_x,
  input  wire logic [15:0] extent_y,
  input  wire logic [15:0] extent_z,
  input  wire logic [63:0] ordinate_pack,
  input  wire logic [47:0] face_colours,
  input  wire logic [2:0]  pyramid_type,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       face_number,
  output logic [1:0]       corner_number,
  output logic [16:0]      vertex_x,
  output logic [16:0]      vertex_y,
  output logic [16:0]      vertex_z,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic             last,
  output logic             bad_type
);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic signed [8:0] key_colour;
  logic              direct_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_colour  <= -9'sd1;
      direct_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pfe_pkg::CFG_KEY_COLOUR:  key_colour  <= cfg_data;
        pfe_pkg::CFG_DIRECT_MODE: direct_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic                    in_fire;
  logic                    is_expand;
  logic                    type_bad;
  logic [pfe_pkg::NUM_FACES-1:0] drawn_in;
  logic                    pal_we;
  logic                    map_we;

  assign in_fire   = in_valid && in_ready;
  assign is_expand = (action == pfe_pkg::ACT_EXPAND);
  assign type_bad  = (pyramid_type >= 3'(pfe_pkg::NUM_TYPES));
  assign pal_we    = in_fire && (action == pfe_pkg::ACT_PAL_WR) &&
                     ({1'b0, table_index} < 9'(pfe_pkg::PALETTE_ENTRIES));
  assign map_we    = in_fire && (action == pfe_pkg::ACT_MAP_WR) &&
                     ({1'b0, table_index} < 9'(pfe_pkg::MAP_ENTRIES));

  // key match per face; negative key disables keying
  always_comb begin
    for (int f = 0; f < pfe_pkg::NUM_FACES; f++) begin
      drawn_in[f] = !(!key_colour[8] && (key_colour[7:0] == face_colours[8*f +: 8]));
    end
  end

  // ---------------------------------------------------------------------------
  // Issue register: holds the expand being fed into the lookup pipe
  // ---------------------------------------------------------------------------
  logic                          issue_valid;
  logic                          issue_bad;
  pfe_pkg::geom_t                issue_geom;
  logic [47:0]                   issue_colours;
  logic [pfe_pkg::NUM_FACES-1:0] issue_drawn;
  logic [2:0]                    issue_face;

  logic [7:0]                    cur_idx;
  logic                          cur_drawn;
  logic                          later_any;
  logic                          credit_ok;
  logic                          issue_push;
  logic                          issue_step;
  logic                          issue_final;
  pfe_pkg::credit_t              inflight;

  // pipeline / queue occupancy, declared here for the credit check
  logic                          s1_valid;
  logic                          s2_valid;
  pfe_pkg::fifo_cnt_t            fifo_count;

  // table writes are interlocked behind faces still to be issued
  assign in_ready = !issue_valid;

  assign cur_idx   = issue_colours[{issue_face, 3'b000} +: 8];
  assign cur_drawn = issue_drawn[issue_face];
  assign later_any = |(issue_drawn & (6'b111110 << issue_face));
  assign inflight  = pfe_pkg::credit_t'(fifo_count) + pfe_pkg::credit_t'(s1_valid) +
                     pfe_pkg::credit_t'(s2_valid);
  assign credit_ok = (inflight < pfe_pkg::credit_t'(pfe_pkg::FIFO_DEPTH));

  assign issue_push  = issue_valid && (issue_bad || cur_drawn) && credit_ok;
  assign issue_step  = issue_push || (issue_valid && !issue_bad && !cur_drawn);
  assign issue_final = issue_bad || !later_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_valid <= 1'b0;
    end else if (in_fire && is_expand) begin
      issue_valid <= type_bad || (|drawn_in);
    end else if (issue_step && issue_final) begin
      issue_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_expand) begin
      issue_bad           <= type_bad;
      issue_colours       <= face_colours;
      issue_drawn         <= drawn_in;
      issue_face          <= 3'd0;
      issue_geom.org_x    <= pfe_pkg::coord_t'(origin_x);
      issue_geom.org_y    <= pfe_pkg::coord_t'(origin_y);
      issue_geom.org_z    <= pfe_pkg::coord_t'(origin_z);
      issue_geom.ext_x    <= pfe_pkg::coord_t'(extent_x);
      issue_geom.ext_y    <= pfe_pkg::coord_t'(extent_y);
      issue_geom.ext_z    <= pfe_pkg::coord_t'(extent_z);
      issue_geom.ord0     <= pfe_pkg::coord_t'(ordinate_pack[15:0]);
      issue_geom.ord1     <= pfe_pkg::coord_t'(ordinate_pack[31:16]);
      issue_geom.ord2     <= pfe_pkg::coord_t'(ordinate_pack[47:32]);
      issue_geom.ord3     <= pfe_pkg::coord_t'(ordinate_pack[63:48]);
      // bad items index the vertex table with type 0, never out of range
      issue_geom.ptype    <= type_bad ? 3'd0 : pyramid_type;
    end else if (issue_step && !issue_final) begin
      issue_face <= issue_face + 3'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tables: colour map and palette, synchronous read
  // ---------------------------------------------------------------------------
  logic [31:0] map_mem [pfe_pkg::MAP_ENTRIES];
  logic [23:0] palette_mem [pfe_pkg::PALETTE_ENTRIES];
  logic [31:0] map_q;
  logic [23:0] pal_q;
  pfe_pkg::pal_addr_t pal_raddr;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[pfe_pkg::map_addr_t'(table_index)] <= table_data;
    end
    map_q <= map_mem[pfe_pkg::map_addr_t'(cur_idx)];
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      palette_mem[pfe_pkg::pal_addr_t'(table_index)] <= table_data[23:0];
    end
    pal_q <= palette_mem[pal_raddr];
  end

  // ---------------------------------------------------------------------------
  // Stage 1: map data back, pick palette index
  // ---------------------------------------------------------------------------
  pfe_pkg::geom_t s1_geom;
  logic [2:0]     s1_face;
  logic [7:0]     s1_idx;
  logic           s1_last;
  logic           s1_bad;
  logic           s1_map_oob;
  logic [31:0]    s1_entry;
  logic [7:0]     s1_pal_idx;
  logic           s1_pal_oob;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue_push;
    end
  end

  always_ff @(posedge clk) begin
    s1_geom    <= issue_geom;
    s1_face    <= issue_bad ? 3'd0 : issue_face;
    s1_idx     <= cur_idx;
    s1_last    <= issue_final;
    s1_bad     <= issue_bad;
    s1_map_oob <= ({1'b0, cur_idx} >= 9'(pfe_pkg::MAP_ENTRIES));
  end

  always_comb begin
    s1_entry = s1_map_oob ? 32'h0 : map_q;
    if ((s1_idx == 8'h00) || direct_mode) begin
      s1_pal_idx = s1_idx;
    end else begin
      s1_pal_idx = pfe_pkg::map_to_index(s1_entry, s1_idx);
    end
    s1_pal_oob = ({1'b0, s1_pal_idx} >= 9'(pfe_pkg::PALETTE_ENTRIES));
    pal_raddr  = pfe_pkg::pal_addr_t'(s1_pal_idx);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: palette data back, push resolved face
  // ---------------------------------------------------------------------------
  pfe_pkg::geom_t      s2_geom;
  logic [2:0]          s2_face;
  logic                s2_last;
  logic                s2_bad;
  logic                s2_pal_oob;
  pfe_pkg::face_entry_t push_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_geom    <= s1_geom;
    s2_face    <= s1_face;
    s2_last    <= s1_last;
    s2_bad     <= s1_bad;
    s2_pal_oob <= s1_pal_oob;
  end

  always_comb begin
    push_entry.geom = s2_geom;
    push_entry.face = s2_face;
    push_entry.rgb  = s2_pal_oob ? 24'h0 : pal_q;
    push_entry.last = s2_last;
    push_entry.bad  = s2_bad;
  end

  // ---------------------------------------------------------------------------
  // Face queue; space is reserved at issue time, so a push never overflows
  // ---------------------------------------------------------------------------
  pfe_pkg::face_entry_t fifo_mem [pfe_pkg::FIFO_DEPTH];
  pfe_pkg::fifo_ptr_t   wr_ptr;
  pfe_pkg::fifo_ptr_t   rd_ptr;
  pfe_pkg::face_entry_t head;
  logic                 fifo_pop;

  assign head = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      fifo_mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= wr_ptr + pfe_pkg::fifo_ptr_t'(1);
      end
      if (fifo_pop) begin
        rd_ptr <= rd_ptr + pfe_pkg::fifo_ptr_t'(1);
      end
      case ({s2_valid, fifo_pop})
        2'b10:   fifo_count <= fifo_count + pfe_pkg::fifo_cnt_t'(1);
        2'b01:   fifo_count <= fifo_count - pfe_pkg::fifo_cnt_t'(1);
        default: fifo_count <= fifo_count;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Emitter: four corners per face (one item for a bad face) into the output register
  // ---------------------------------------------------------------------------
  logic [1:0]      corner;
  logic            emit_load;
  logic [2:0]      vtx;
  pfe_pkg::vert_t  vx;
  pfe_pkg::vert_t  vy;
  pfe_pkg::vert_t  vz;

  assign emit_load = (fifo_count != '0) && (!out_valid || out_ready);
  assign fifo_pop  = emit_load && (head.bad || (corner == 2'd3));

  always_comb begin
    vtx = pfe_pkg::FACE_CORNERS[head.face][corner];
    vx  = pfe_pkg::vertex_coord(head.geom.org_x,
            pfe_pkg::sel_value(head.geom, pfe_pkg::VERT_RULE[head.geom.ptype][vtx][0]));
    vy  = pfe_pkg::vertex_coord(head.geom.org_y,
            pfe_pkg::sel_value(head.geom, pfe_pkg::VERT_RULE[head.geom.ptype][vtx][1]));
    vz  = pfe_pkg::vertex_coord(head.geom.org_z,
            pfe_pkg::sel_value(head.geom, pfe_pkg::VERT_RULE[head.geom.ptype][vtx][2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner <= 2'd0;
    end else if (fifo_pop) begin
      corner <= 2'd0;
    end else if (emit_load) begin
      corner <= corner + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      if (head.bad) begin
        face_number   <= 3'd0;
        corner_number <= 2'd0;
        vertex_x      <= '0;
        vertex_y      <= '0;
        vertex_z      <= '0;
        red           <= 8'h00;
        green         <= 8'h00;
        blue          <= 8'h00;
        last          <= 1'b1;
        bad_type      <= 1'b1;
      end else begin
        face_number   <= head.face;
        corner_number <= corner;
        vertex_x      <= vx;
        vertex_y      <= vy;
        vertex_z      <= vz;
        red           <= head.rgb[23:16];
        green         <= head.rgb[15:8];
        blue          <= head.rgb[7:0];
        last          <= head.last && (corner == 2'd3);
        bad_type      <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PFE_ASSERT(a_credit_bound, inflight <= pfe_pkg::credit_t'(pfe_pkg::FIFO_DEPTH), "face queue overcommitted")

  `PFE_ASSERT(a_bad_is_final, out_valid && bad_type |-> last && (vertex_x == '0) && (red == 8'h00), "bad type item malformed")

  `PFE_ASSERT_NEXT(a_bad_issue, in_fire && is_expand && type_bad, issue_valid && issue_bad, "bad type expand not queued")

endmodule

`default_nettype wire
